/* rtl/radio_reply_frame_parser_macros.svh */
// Assertion macros used by the frame parser checker
`ifndef RADIO_REPLY_FRAME_PARSER_MACROS_SVH
`define RADIO_REPLY_FRAME_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RRFP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrfp check failed");

// next-cycle implication, sampled on clk, off during reset
`define RRFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrfp check failed");

`endif

/* rtl/rrfp_pkg.sv */
// Types and constants of the radio reply frame parser
package rrfp_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hFE;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_NODE_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_PORT          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_PORT            = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RETURN_ADDRESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RETURN_NETID   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RETURN_CHANNEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_RETURN_UART    = 3'd6;

    typedef enum logic [3:0] {
        KIND_BAD_TAIL    = 4'd0,
        KIND_ADDRESS     = 4'd1,
        KIND_NETID       = 4'd2,
        KIND_CHANNEL     = 4'd3,
        KIND_BAUD        = 4'd4,
        KIND_LOCAL_OTHER = 4'd5,
        KIND_IMU_CALIB   = 4'd6,
        KIND_MAG_CALIB   = 4'd7,
        KIND_OTHER       = 4'd8
    } kind_t;

    typedef struct packed {
        logic [15:0] main_node_address;
        logic [7:0]  calib_port;
        logic [7:0]  mag_port;
        logic [7:0]  code_return_address;
        logic [7:0]  code_return_netid;
        logic [7:0]  code_return_channel;
        logic [7:0]  code_return_uart;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        main_node_address:   16'd1,
        calib_port:          8'd161,
        mag_port:            8'd162,
        code_return_address: 8'd33,
        code_return_netid:   8'd34,
        code_return_channel: 8'd35,
        code_return_uart:    8'd36
    };

    // frame offsets 3..8: port, source low, source high, code, value low, value high
    typedef logic [5:0][7:0] hdr_t;

endpackage

/* rtl/radio_reply_frame_parser.sv */
// Top level of the radio reply frame parser
//
//   channel  signals                         width  direction
//   in       in_valid/in_ready, rx_byte      8      sink
//   out      out_valid/out_ready, kind ...   4..16  source
//   cfg      cfg_we, cfg_index, cfg_data     3/16   sink, write only
//
// One byte per cycle while no result is stalled; a tail byte gives its result in the cycle after the transfer.
// The parse state and result register update in the same cycle as the byte.
// A result held by a stalled sink blocks the next byte; none is dropped.
// Reset returns to header hunt and clears the header window and stored values.
module radio_reply_frame_parser #(
    parameter int LEN_LIMIT = 50
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rrfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [3:0]                        kind,
    output logic [15:0]                       module_address,
    output logic [15:0]                       network_id,
    output logic [7:0]                        channel,
    output logic [7:0]                        baud_code,
    output logic [7:0]                        accel_cal,
    output logic [7:0]                        gyro_cal,
    output logic [7:0]                        mag_cal
);
    import rrfp_pkg::*;

    localparam int CW = $clog2(LEN_LIMIT);
    localparam logic [8:0] LEN_LIMIT_W = 9'(LEN_LIMIT);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_PAYLOAD,
        PH_TAIL
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] bytes_left_reg, bytes_left_next;
    logic [CW-1:0] count_reg, count_next;
    hdr_t          hdr_reg, hdr_next, hdr_merge;
    cfg_t          cfg_reg;
    logic [15:0]   addr_reg, addr_next;
    logic [15:0]   netid_reg, netid_next;
    logic [7:0]    chan_reg, chan_next;
    logic [7:0]    baud_reg, baud_next;
    logic [7:0]    acc_reg, acc_next;
    logic [7:0]    gyro_reg, gyro_next;
    logic [7:0]    mag_reg, mag_next;
    kind_t         kind_reg, kind_next;
    logic          out_valid_reg, out_valid_next;
    kind_t         dec_kind;
    logic          accept;

    rrfp_decode u_decode (
        .hdr  (hdr_merge),
        .cfg  (cfg_reg),
        .kind (dec_kind)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hdr_merge = hdr_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (count_reg == CW'(i + 1))
                hdr_merge[i] = rx_byte;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        count_next      = count_reg;
        hdr_next        = hdr_reg;
        addr_next       = addr_reg;
        netid_next      = netid_reg;
        chan_next       = chan_reg;
        baud_next       = baud_reg;
        acc_next        = acc_reg;
        gyro_next       = gyro_reg;
        mag_next        = mag_reg;
        kind_next       = kind_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_BYTE)
                        phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} < LEN_LIMIT_W)
                    begin
                        phase_next      = PH_PAYLOAD;
                        bytes_left_next = CW'(rx_byte);
                        count_next      = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (bytes_left_reg == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        hdr_next        = hdr_merge;
                        count_next      = count_reg + CW'(1);
                        bytes_left_next = bytes_left_reg - CW'(1);
                        if (bytes_left_reg == CW'(1))
                            phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    phase_next     = PH_HUNT;
                    hdr_next       = hdr_merge;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BAD_TAIL;
                    if (rx_byte == TAIL_BYTE)
                    begin
                        kind_next = dec_kind;
                        case (dec_kind)
                            KIND_ADDRESS:   addr_next  = {hdr_merge[5], hdr_merge[4]};
                            KIND_NETID:     netid_next = {hdr_merge[5], hdr_merge[4]};
                            KIND_CHANNEL:   chan_next  = hdr_merge[4];
                            KIND_BAUD:      baud_next  = hdr_merge[4];
                            KIND_IMU_CALIB:
                            begin
                                acc_next  = hdr_merge[3];
                                gyro_next = hdr_merge[4];
                            end
                            KIND_MAG_CALIB: mag_next   = hdr_merge[3];
                            default:        ;
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAIN_NODE_ADDRESS:   cfg_reg.main_node_address   <= cfg_data;
                CFG_CALIB_PORT:          cfg_reg.calib_port          <= cfg_data[7:0];
                CFG_MAG_PORT:            cfg_reg.mag_port            <= cfg_data[7:0];
                CFG_CODE_RETURN_ADDRESS: cfg_reg.code_return_address <= cfg_data[7:0];
                CFG_CODE_RETURN_NETID:   cfg_reg.code_return_netid   <= cfg_data[7:0];
                CFG_CODE_RETURN_CHANNEL: cfg_reg.code_return_channel <= cfg_data[7:0];
                CFG_CODE_RETURN_UART:    cfg_reg.code_return_uart    <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            count_reg      <= '0;
            hdr_reg        <= '0;
            addr_reg       <= '0;
            netid_reg      <= '0;
            chan_reg       <= '0;
            baud_reg       <= '0;
            acc_reg        <= '0;
            gyro_reg       <= '0;
            mag_reg        <= '0;
            kind_reg       <= KIND_BAD_TAIL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            count_reg      <= count_next;
            hdr_reg        <= hdr_next;
            addr_reg       <= addr_next;
            netid_reg      <= netid_next;
            chan_reg       <= chan_next;
            baud_reg       <= baud_next;
            acc_reg        <= acc_next;
            gyro_reg       <= gyro_next;
            mag_reg        <= mag_next;
            kind_reg       <= kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign module_address = addr_reg;
    assign network_id     = netid_reg;
    assign channel        = chan_reg;
    assign baud_code      = baud_reg;
    assign accel_cal      = acc_reg;
    assign gyro_cal       = gyro_reg;
    assign mag_cal        = mag_reg;

endmodule

/* rtl/rrfp_decode.sv */
// Frame classifier: source address, destination port and reply code to result kind
module rrfp_decode (
    input  rrfp_pkg::hdr_t  hdr,
    input  rrfp_pkg::cfg_t  cfg,
    output rrfp_pkg::kind_t kind
);
    import rrfp_pkg::*;

    logic [15:0] src;
    logic [7:0]  port;
    logic [7:0]  code;

    assign src  = {hdr[2], hdr[1]};
    assign port = hdr[0];
    assign code = hdr[3];

    always_comb
    begin
        kind = KIND_OTHER;
        if (src == 16'd0)
        begin
            if (code == cfg.code_return_address)
                kind = KIND_ADDRESS;
            else if (code == cfg.code_return_netid)
                kind = KIND_NETID;
            else if (code == cfg.code_return_channel)
                kind = KIND_CHANNEL;
            else if (code == cfg.code_return_uart)
                kind = KIND_BAUD;
            else
                kind = KIND_LOCAL_OTHER;
        end
        else if (src == cfg.main_node_address)
        begin
            if (port == cfg.calib_port)
                kind = KIND_IMU_CALIB;
            else if (port == cfg.mag_port)
                kind = KIND_MAG_CALIB;
        end
    end

endmodule

/* rtl/rrfp_checker.sv */
// Port-level checks of the radio reply frame parser and their bind
`include "radio_reply_frame_parser_macros.svh"

module rrfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  kind,
    input logic [15:0] module_address,
    input logic [15:0] network_id
);
    import rrfp_pkg::*;

    `RRFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind))
    `RRFP_ASSERT_IMPLY(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
    `RRFP_ASSERT_IMPLY(a_kind_range, out_valid, kind <= KIND_OTHER)
    `RRFP_ASSERT_IMPLY(a_addr_update, !$stable(module_address), out_valid && kind == KIND_ADDRESS)
    `RRFP_ASSERT_IMPLY(a_netid_update, !$stable(network_id), out_valid && kind == KIND_NETID)

endmodule

bind radio_reply_frame_parser rrfp_checker u_rrfp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .module_address (module_address),
    .network_id     (network_id)
);

/* sim/tb.sv */
// Self-checking testbench for the radio reply frame parser
`timescale 1ns / 100ps

module tb;

    import rrfp_pkg::*;

    localparam int FRAME_LEN_LIMIT = 50;

    typedef enum logic [1:0] {
        PARSE_HUNT,
        PARSE_LEN,
        PARSE_PAYLOAD,
        PARSE_TAIL
    } parse_phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] module_address;
        logic [15:0] network_id;
        logic [7:0]  channel;
        logic [7:0]  baud_code;
        logic [7:0]  accel_cal;
        logic [7:0]  gyro_cal;
        logic [7:0]  mag_cal;
    } reply_t;

    class reply_scoreboard;
        cfg_t         cfg;
        parse_phase_t phase;
        int unsigned  bytes_left;
        int unsigned  payload_count;
        hdr_t         win;
        logic [15:0]  module_address;
        logic [15:0]  network_id;
        logic [7:0]   channel;
        logic [7:0]   baud_code;
        logic [7:0]   acc_flag;
        logic [7:0]   gyro_flag;
        logic [7:0]   mag_flag;
        reply_t       expected_replies [$];
        int           errors;

        function new();
            cfg            = CFG_RESET;
            phase          = PARSE_HUNT;
            bytes_left     = 0;
            payload_count  = 0;
            win            = '0;
            module_address = '0;
            network_id     = '0;
            channel        = '0;
            baud_code      = '0;
            acc_flag       = '0;
            gyro_flag      = '0;
            mag_flag       = '0;
            errors         = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAIN_NODE_ADDRESS:   cfg.main_node_address   = data;
                CFG_CALIB_PORT:          cfg.calib_port          = data[7:0];
                CFG_MAG_PORT:            cfg.mag_port            = data[7:0];
                CFG_CODE_RETURN_ADDRESS: cfg.code_return_address = data[7:0];
                CFG_CODE_RETURN_NETID:   cfg.code_return_netid   = data[7:0];
                CFG_CODE_RETURN_CHANNEL: cfg.code_return_channel = data[7:0];
                CFG_CODE_RETURN_UART:    cfg.code_return_uart    = data[7:0];
                default: ;
            endcase
        endfunction

        function void keep_at(int unsigned off, logic [7:0] b);
            if (off >= 3 && off <= 8)
                win[off-3] = b;
        endfunction

        function kind_t decode_frame();
            logic [15:0] src;
            src = {win[2], win[1]};
            if (src == 16'h0000)
            begin
                if (win[3] == cfg.code_return_address)
                begin
                    module_address = {win[5], win[4]};
                    return KIND_ADDRESS;
                end
                if (win[3] == cfg.code_return_netid)
                begin
                    network_id = {win[5], win[4]};
                    return KIND_NETID;
                end
                if (win[3] == cfg.code_return_channel)
                begin
                    channel = win[4];
                    return KIND_CHANNEL;
                end
                if (win[3] == cfg.code_return_uart)
                begin
                    baud_code = win[4];
                    return KIND_BAUD;
                end
                return KIND_LOCAL_OTHER;
            end
            if (src == cfg.main_node_address)
            begin
                if (win[0] == cfg.calib_port)
                begin
                    acc_flag  = win[3];
                    gyro_flag = win[4];
                    return KIND_IMU_CALIB;
                end
                if (win[0] == cfg.mag_port)
                begin
                    mag_flag = win[3];
                    return KIND_MAG_CALIB;
                end
            end
            return KIND_OTHER;
        endfunction

        function void take_byte(logic [7:0] b);
            reply_t r;
            kind_t  k;
            case (phase)
                PARSE_HUNT:
                    if (b == HDR_BYTE)
                        phase = PARSE_LEN;
                PARSE_LEN:
                    if (b < FRAME_LEN_LIMIT)
                    begin
                        phase         = PARSE_PAYLOAD;
                        bytes_left    = b;
                        payload_count = 0;
                    end
                    else
                        phase = PARSE_HUNT;
                PARSE_PAYLOAD:
                    if (bytes_left == 0)
                        phase = PARSE_HUNT;
                    else
                    begin
                        keep_at(2 + payload_count, b);
                        payload_count++;
                        bytes_left--;
                        if (bytes_left == 0)
                            phase = PARSE_TAIL;
                    end
                default:
                begin
                    phase = PARSE_HUNT;
                    keep_at(2 + payload_count, b);
                    if (b == TAIL_BYTE)
                        k = decode_frame();
                    else
                        k = KIND_BAD_TAIL;
                    r.kind           = k;
                    r.module_address = module_address;
                    r.network_id     = network_id;
                    r.channel        = channel;
                    r.baud_code      = baud_code;
                    r.accel_cal      = acc_flag;
                    r.gyro_cal       = gyro_flag;
                    r.mag_cal        = mag_flag;
                    expected_replies.push_back(r);
                end
            endcase
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: reply with none expected, actual kind %h", $time, got.kind);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            compare("kind", 16'(want.kind), 16'(got.kind));
            compare("module_address", want.module_address, got.module_address);
            compare("network_id", want.network_id, got.network_id);
            compare("channel", 16'(want.channel), 16'(got.channel));
            compare("baud_code", 16'(want.baud_code), 16'(got.baud_code));
            compare("accel_cal", 16'(want.accel_cal), 16'(got.accel_cal));
            compare("gyro_cal", 16'(want.gyro_cal), 16'(got.gyro_cal));
            compare("mag_cal", 16'(want.mag_cal), 16'(got.mag_cal));
        endfunction
    endclass

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int FRAME_BYTES     = 1400;
    localparam int N_PHASES        = 6;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [3:0]            kind;
    logic [15:0]           module_address;
    logic [15:0]           network_id;
    logic [7:0]            channel;
    logic [7:0]            baud_code;
    logic [7:0]            accel_cal;
    logic [7:0]            gyro_cal;
    logic [7:0]            mag_cal;

    reply_scoreboard sb;
    bit              in_fast;
    bit              out_fast;
    bit              hold_off_req;
    int              frame_bytes;
    int              cycles;

    radio_reply_frame_parser #(.LEN_LIMIT(FRAME_LEN_LIMIT)) i_dut (.*);

    always #6 clk = ~clk;

    function automatic int draw_gap(bit fast);
        return fast ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic hdr_t mk_hdr(logic [7:0] port, logic [15:0] src, logic [7:0] code,
                                    logic [7:0] v_lo, logic [7:0] v_hi);
        return {v_hi, v_lo, code, src[15:8], src[7:0], port};
    endfunction

    // start and end at a rising edge; valid stays high back to back when gap is zero
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(in_fast);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(negedge clk); while (in_ready !== 1'b1);
        @(posedge clk);
        sb.take_byte(b);
    endtask

    // for a zero length the tail argument is the byte that gets dropped
    task automatic send_frame(input int len, input hdr_t h, input logic [7:0] tail);
        send_byte(HDR_BYTE);
        send_byte(8'(len));
        frame_bytes += 2;
        if (len >= FRAME_LEN_LIMIT)
            return;
        for (int off = 2; off <= len + 1; off++)
        begin
            if (off >= 3 && off <= 8)
                send_byte(h[off-3]);
            else
                send_byte(8'($urandom));
        end
        send_byte(tail);
        frame_bytes += len + 1;
    endtask

    task automatic send_random_frame();
        hdr_t        h;
        int          len;
        int          pick;
        logic [15:0] src;
        logic [7:0]  port;
        logic [7:0]  code;
        logic [7:0]  tail;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            src = 16'h0000;
        else if (pick < 75)
            src = sb.cfg.main_node_address;
        else
            src = 16'($urandom);
        case ($urandom_range(0, 2))
            0:       port = sb.cfg.calib_port;
            1:       port = sb.cfg.mag_port;
            default: port = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       code = sb.cfg.code_return_address;
            1:       code = sb.cfg.code_return_netid;
            2:       code = sb.cfg.code_return_channel;
            3:       code = sb.cfg.code_return_uart;
            default: code = 8'($urandom);
        endcase
        h = mk_hdr(port, src, code, 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(7, 12);
        else if (pick < 82)
            len = $urandom_range(1, 6);
        else if (pick < 90)
            len = $urandom_range(13, FRAME_LEN_LIMIT - 1);
        else if (pick < 94)
            len = 0;
        else if (pick < 97)
            len = $urandom_range(FRAME_LEN_LIMIT, 255);
        else
            len = FRAME_LEN_LIMIT - 1;
        tail = ($urandom_range(0, 9) == 0) ? 8'($urandom) : TAIL_BYTE;
        in_fast = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        send_frame(len, h, tail);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // upper data bits of the byte-wide registers are junk and must be dropped
    task automatic write_setting(input cfg_t c);
        write_reg(CFG_MAIN_NODE_ADDRESS, c.main_node_address);
        write_reg(CFG_CALIB_PORT, {8'($urandom), c.calib_port});
        write_reg(CFG_MAG_PORT, {8'($urandom), c.mag_port});
        write_reg(CFG_CODE_RETURN_ADDRESS, {8'($urandom), c.code_return_address});
        write_reg(CFG_CODE_RETURN_NETID, {8'($urandom), c.code_return_netid});
        write_reg(CFG_CODE_RETURN_CHANNEL, {8'($urandom), c.code_return_channel});
        write_reg(CFG_CODE_RETURN_UART, {8'($urandom), c.code_return_uart});
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_phase_setting(input int p);
        cfg_t c;
        logic [7:0] same;
        c = CFG_RESET;
        case (p)
            1: c = '0;
            2: c = '1;
            3: c = cfg_t'({$urandom, $urandom});
            4:
            begin
                same = 8'($urandom);
                c.main_node_address   = 16'($urandom);
                c.calib_port          = 8'($urandom);
                c.mag_port            = c.calib_port;
                c.code_return_address = same;
                c.code_return_netid   = same;
                c.code_return_channel = same;
                c.code_return_uart    = same;
            end
            default: ;
        endcase
        write_setting(c);
        if (p == 4 || p == 5)
            write_reg(CFG_IDX_W'(7), 16'($urandom));
    endtask

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        reply_t got;
        int     gap;
        out_ready <= 1'b0;
        out_fast = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    out_fast = !out_fast;
                gap = draw_gap(out_fast);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (out_valid !== 1'b1);
            got.kind           = kind;
            got.module_address = module_address;
            got.network_id     = network_id;
            got.channel        = channel;
            got.baud_code      = baud_code;
            got.accel_cal      = accel_cal;
            got.gyro_cal       = gyro_cal;
            got.mag_cal        = mag_cal;
            sb.check_reply(got);
            @(posedge clk);
        end
    end

    initial
    begin
        sb = new();
        in_fast      = 1'b0;
        hold_off_req = 1'b0;
        frame_bytes  = 0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        rx_byte   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(7, mk_hdr(8'h00, 16'h0000, 8'd33, 8'h34, 8'h12), TAIL_BYTE);
        send_frame(8, mk_hdr(8'hFF, 16'h0000, 8'd34, 8'hFF, 8'hFF), TAIL_BYTE);
        send_frame(7, mk_hdr(8'h00, 16'h0000, 8'd35, 8'hA5, 8'h00), TAIL_BYTE);
        send_frame(7, mk_hdr(8'h00, 16'h0000, 8'd36, 8'h07, 8'h00), TAIL_BYTE);
        send_frame(7, mk_hdr(8'h00, 16'h0000, 8'h00, 8'h11, 8'h22), TAIL_BYTE);
        send_frame(7, mk_hdr(8'd161, 16'h0001, 8'h01, 8'h80, 8'h00), TAIL_BYTE);
        send_frame(7, mk_hdr(8'd162, 16'h0001, 8'hFF, 8'h00, 8'h00), TAIL_BYTE);
        send_frame(7, mk_hdr(8'h10, 16'h0001, 8'h55, 8'h66, 8'h77), TAIL_BYTE);
        send_frame(7, mk_hdr(8'd161, 16'hFFFF, 8'h01, 8'h01, 8'h01), TAIL_BYTE);
        send_frame(7, mk_hdr(8'h00, 16'h0000, 8'd33, 8'hAA, 8'hBB), 8'h00);
        send_frame(FRAME_LEN_LIMIT, '0, TAIL_BYTE);
        send_frame(255, '0, TAIL_BYTE);
        send_frame(FRAME_LEN_LIMIT - 1, mk_hdr(8'h00, 16'h0000, 8'd34, 8'h01, 8'h80),
                   TAIL_BYTE);
        send_frame(0, '0, HDR_BYTE);
        send_byte(8'h05);
        send_frame(1, '0, TAIL_BYTE);
        send_frame(3, mk_hdr(8'd161, 16'h0001, 8'h00, 8'h00, 8'h00), TAIL_BYTE);
        send_frame(6, mk_hdr(8'h00, 16'h0000, 8'd33, 8'h3C, 8'h00), TAIL_BYTE);
        send_frame(2, '0, 8'h00);
        drain_replies();

        frame_bytes = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p > 0)
                apply_phase_setting(p);
            if (p == 3)
            begin
                hold_off_req = 1'b1;
                in_fast = 1'b1;
                repeat (8) send_frame(1, '0, TAIL_BYTE);
            end
            while (frame_bytes < FRAME_BYTES * (p + 1) / N_PHASES)
                send_random_frame();
            drain_replies();
        end

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
